// ----- hw/rtl/smn_pkg.sv -----
// ----------------------------------------------------------------------------
// smn_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package smn_pkg;

	localparam int SIEVE_LIMIT = 16384;
	localparam int HALF_LIMIT  = SIEVE_LIMIT / 2;
	localparam int NUM_W       = 14;
	localparam int FSUM_W      = 7;
	localparam int NSUM_W      = 6;
	localparam int MEM_AW      = $clog2(HALF_LIMIT + 1);
	localparam int K_W         = NUM_W - 1;
	localparam int SV_W        = MEM_AW + 2;
	localparam int CNT_W       = $clog2(NUM_W);
	// floor(v/10) == (v*RECIP)>>16 within one for 14-bit v
	localparam int RECIP       = 6554;
	localparam int PROD_W      = NUM_W + 13;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR,
		OP_SV_INIT,
		OP_SV_MARK,
		OP_SV_NEXT,
		OP_LOAD,
		OP_DS_MUL,
		OP_DS_STEP,
		OP_SAVE_N,
		OP_ADD_F,
		OP_DV_LOAD,
		OP_DV_STEP,
		OP_STRIP,
		OP_NEXT_K,
		OP_MRD,
		OP_DS_LOAD_R,
		OP_RES,
		OP_RES_ZERO
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic sv_outer_ok;
		logic sv_j_ok;
		logic ds_zero;
		logic dv_last;
		logic dv_exact;
		logic p_over;
		logic mark;
		logic n_zero;
		logic n_small;
		logic rem_final;
	} sts_t;

endpackage

// ----- hw/rtl/smn_datapath.sv -----
// ----------------------------------------------------------------------------
// smn_datapath
// Sieve memory, trial divider, digit-sum unit and result registers.
// ----------------------------------------------------------------------------
module smn_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  smn_pkg::cmd_t                 cmd,
	output smn_pkg::sts_t                 sts,
	input  logic [smn_pkg::NUM_W-1:0]     number,
	output logic                          is_smith,
	output logic [smn_pkg::FSUM_W-1:0]    factor_digit_sum,
	output logic [smn_pkg::NSUM_W-1:0]    number_digit_sum
);
	import smn_pkg::*;

	logic                 mem [0:HALF_LIMIT];
	logic [MEM_AW-1:0]    clr_q;
	logic [SV_W-1:0]      i_q, start_q, step_q, j_q;
	logic [NUM_W-1:0]     n_q, rem_q, p_q;
	logic [K_W-1:0]       k_q;
	logic                 mark_q;
	logic [FSUM_W-1:0]    fsum_q;
	logic [NSUM_W-1:0]    nds_q;
	logic [NUM_W-1:0]     dv_q;
	logic [PROD_W-1:0]    prod_s1;
	logic [NSUM_W-1:0]    dsum_q;
	logic [NUM_W-1:0]     dq_q, dr_q;
	logic [CNT_W-1:0]     cnt_q;

	logic [NUM_W-1:0]     q_est, q_fix;
	logic [NUM_W-1:0]     r_est;
	logic [3:0]           r_fix;
	logic [NUM_W:0]       dv_trial;
	logic [NUM_W:0]       dv_diff;
	logic [K_W-1:0]       k_nxt;
	logic [SV_W-1:0]      i_nxt;

	// digit step: quotient estimate from the registered product, one correction
	always_comb begin
		q_est = NUM_W'(prod_s1[PROD_W-1:16]);
		r_est = dv_q - NUM_W'(q_est * NUM_W'(10));
		if (r_est >= NUM_W'(10)) begin
			q_fix = q_est + NUM_W'(1);
			r_fix = 4'(r_est - NUM_W'(10));
		end else begin
			q_fix = q_est;
			r_fix = 4'(r_est);
		end
	end

	assign dv_trial = {dr_q, dq_q[NUM_W-1]};
	assign dv_diff  = dv_trial - {1'b0, p_q};
	assign k_nxt    = k_q + K_W'(1);
	assign i_nxt    = i_q + SV_W'(1);

	always_comb begin
		sts.clr_last    = (clr_q == MEM_AW'(HALF_LIMIT));
		sts.sv_outer_ok = (start_q <= SV_W'(HALF_LIMIT));
		sts.sv_j_ok     = (j_q <= SV_W'(HALF_LIMIT));
		sts.ds_zero     = (dv_q == '0);
		sts.dv_last     = (cnt_q == CNT_W'(NUM_W - 1));
		sts.dv_exact    = (dr_q == '0);
		sts.p_over      = (p_q > (rem_q >> 1));
		sts.mark        = mark_q;
		sts.n_zero      = (n_q == '0);
		sts.n_small     = (n_q < NUM_W'(4));
		sts.rem_final   = (rem_q != NUM_W'(1)) && (rem_q != n_q);
	end

	// sieve table: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.op == OP_CLR)
			mem[clr_q] <= 1'b0;
		else if (cmd.op == OP_SV_MARK)
			mem[j_q[MEM_AW-1:0]] <= 1'b1;
		if (cmd.op == OP_MRD)
			mark_q <= mem[MEM_AW'(k_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.op == OP_CLR && clr_q != MEM_AW'(HALF_LIMIT)) begin
			clr_q <= clr_q + MEM_AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_SV_INIT: begin
				i_q     <= SV_W'(1);
				start_q <= SV_W'(4);
				j_q     <= SV_W'(4);
				step_q  <= SV_W'(3);
			end
			OP_SV_MARK: j_q <= j_q + step_q;
			OP_SV_NEXT: begin
				// 2i(i+1) grows by 4(i+1)
				i_q     <= i_nxt;
				start_q <= start_q + (i_nxt << 2);
				j_q     <= start_q + (i_nxt << 2);
				step_q  <= step_q + SV_W'(2);
			end
			OP_LOAD: begin
				n_q    <= number;
				rem_q  <= number;
				fsum_q <= '0;
				dv_q   <= number;
				dsum_q <= '0;
			end
			OP_DS_MUL: prod_s1 <= PROD_W'(dv_q) * PROD_W'(RECIP);
			OP_DS_STEP: begin
				dv_q   <= q_fix;
				dsum_q <= dsum_q + NSUM_W'(r_fix);
			end
			OP_SAVE_N: begin
				nds_q <= dsum_q;
				p_q   <= NUM_W'(2);
				k_q   <= '0;
			end
			OP_ADD_F: fsum_q <= fsum_q + FSUM_W'(dsum_q);
			OP_DV_LOAD: begin
				dq_q  <= rem_q;
				dr_q  <= '0;
				cnt_q <= '0;
			end
			OP_DV_STEP: begin
				if (!dv_diff[NUM_W]) begin
					dr_q <= dv_diff[NUM_W-1:0];
					dq_q <= {dq_q[NUM_W-2:0], 1'b1};
				end else begin
					dr_q <= dv_trial[NUM_W-1:0];
					dq_q <= {dq_q[NUM_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
			OP_STRIP: begin
				rem_q  <= dq_q;
				dv_q   <= p_q;
				dsum_q <= '0;
			end
			OP_NEXT_K: begin
				k_q <= k_nxt;
				p_q <= {k_nxt, 1'b1};
			end
			OP_DS_LOAD_R: begin
				dv_q   <= rem_q;
				dsum_q <= '0;
			end
			OP_RES: begin
				is_smith         <= (fsum_q == FSUM_W'(nds_q));
				factor_digit_sum <= fsum_q;
				number_digit_sum <= nds_q;
			end
			OP_RES_ZERO: begin
				is_smith         <= 1'b0;
				factor_digit_sum <= '0;
				number_digit_sum <= nds_q;
			end
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/smn_ctrl.sv -----
// ----------------------------------------------------------------------------
// smn_ctrl
// Sequencer: table clear, sieve pass, digit sums and trial division.
// ----------------------------------------------------------------------------
module smn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output smn_pkg::cmd_t cmd,
	input  smn_pkg::sts_t sts
);
	import smn_pkg::*;

	typedef enum logic [15:0] {
		S_CLR  = 16'h0001,
		S_SVI  = 16'h0002,
		S_SVO  = 16'h0004,
		S_SVM  = 16'h0008,
		S_IDLE = 16'h0010,
		S_DSM  = 16'h0020,
		S_DSS  = 16'h0040,
		S_DVL  = 16'h0080,
		S_DVS  = 16'h0100,
		S_DVC  = 16'h0200,
		S_PCHK = 16'h0400,
		S_MCHK = 16'h0800,
		S_RCHK = 16'h1000,
		S_RES  = 16'h2000,
		S_RESZ = 16'h4000,
		S_MRD  = 16'h8000
	} state_t;

	typedef enum logic [1:0] {
		DK_N,
		DK_P,
		DK_R
	} dkind_t;

	state_t state_q, state_d;
	dkind_t kind_q, kind_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_CLR: begin
				cmd.op = OP_CLR;
				if (sts.clr_last)
					state_d = S_SVI;
			end
			S_SVI: begin
				cmd.op  = OP_SV_INIT;
				state_d = S_SVO;
			end
			S_SVO: state_d = sts.sv_outer_ok ? S_SVM : S_IDLE;
			S_SVM: begin
				if (sts.sv_j_ok) begin
					cmd.op = OP_SV_MARK;
				end else begin
					cmd.op  = OP_SV_NEXT;
					state_d = S_SVO;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					kind_d  = DK_N;
					state_d = S_DSM;
				end
			end
			S_DSM: begin
				if (sts.ds_zero) begin
					case (kind_q)
						DK_N: begin
							cmd.op = OP_SAVE_N;
							if (sts.n_zero)
								state_d = S_RESZ;
							else if (sts.n_small)
								state_d = S_RCHK;
							else
								state_d = S_DVL;
						end
						DK_P: begin
							cmd.op  = OP_ADD_F;
							state_d = S_DVL;
						end
						default: begin
							cmd.op  = OP_ADD_F;
							state_d = S_RES;
						end
					endcase
				end else begin
					cmd.op  = OP_DS_MUL;
					state_d = S_DSS;
				end
			end
			S_DSS: begin
				cmd.op  = OP_DS_STEP;
				state_d = S_DSM;
			end
			S_DVL: begin
				cmd.op  = OP_DV_LOAD;
				state_d = S_DVS;
			end
			S_DVS: begin
				cmd.op = OP_DV_STEP;
				if (sts.dv_last)
					state_d = S_DVC;
			end
			S_DVC: begin
				if (sts.dv_exact) begin
					cmd.op  = OP_STRIP;
					kind_d  = DK_P;
					state_d = S_DSM;
				end else begin
					cmd.op  = OP_NEXT_K;
					state_d = S_PCHK;
				end
			end
			S_PCHK: state_d = sts.p_over ? S_RCHK : S_MRD;
			S_MRD: begin
				cmd.op  = OP_MRD;
				state_d = S_MCHK;
			end
			S_MCHK: begin
				if (sts.mark) begin
					cmd.op  = OP_NEXT_K;
					state_d = S_PCHK;
				end else begin
					state_d = S_DVL;
				end
			end
			S_RCHK: begin
				if (sts.rem_final) begin
					cmd.op  = OP_DS_LOAD_R;
					kind_d  = DK_R;
					state_d = S_DSM;
				end else begin
					state_d = S_RES;
				end
			end
			S_RES: begin
				cmd.op  = OP_RES;
				state_d = S_IDLE;
			end
			S_RESZ: begin
				cmd.op  = OP_RES_ZERO;
				state_d = S_IDLE;
			end
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			kind_q  <= DK_N;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			done_q  <= (state_q == S_RES) || (state_q == S_RESZ);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a test in progress");

	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted word did not start a test");

	a_no_resieve: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |=> state_q != S_CLR && state_q != S_SVI && state_q != S_SVM)
		else $error("sieve pass restarted after ready");

endmodule

// ----- hw/rtl/smith_number_checker.sv -----
// ----------------------------------------------------------------------------
// smith_number_checker
// Smith number test by trial division over a Sundaram sieve table.
// ----------------------------------------------------------------------------
// After reset the block clears its 8193-entry prime table and then runs the
// sieve pass; busy stays high through both.
// A word is taken when start is high and busy is low. A digit sum alternates
// a multiply step and a digit step for each digit. Each trial division runs
// through the bit-serial divider, and stepping to the next odd candidate
// checks its range and reads its mark. So a prime that is tried and does
// not divide costs a division and a step, an odd composite that is skipped
// costs only the step, and a stripped factor costs a division plus its digit
// sum. The result appears for one cycle with done high; the receiver cannot
// stall it.
module smith_number_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [smn_pkg::NUM_W-1:0] number,
	output logic                      done,
	output logic                      is_smith,
	output logic [smn_pkg::FSUM_W-1:0] factor_digit_sum,
	output logic [smn_pkg::NSUM_W-1:0] number_digit_sum
);
	import smn_pkg::*;

	cmd_t cmd;
	sts_t sts;

	smn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	smn_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.number           (number),
		.is_smith         (is_smith),
		.factor_digit_sum (factor_digit_sum),
		.number_digit_sum (number_digit_sum)
	);

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks the Smith number block against a behavioral predictor. Directed
// words cover the field maximum, one, primes, prime powers and known Smith
// numbers; random words follow, with the sender gap rate changed per phase.
// ----------------------------------------------------------------------------
module tb;
	import smn_pkg::*;

	typedef struct packed {
		logic              smith;
		logic [FSUM_W-1:0] fsum;
		logic [NSUM_W-1:0] nsum;
	} smith_res_t;

	localparam int WATCHDOG = 200000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic [NUM_W-1:0]  number;
	logic              busy;
	logic              done;
	logic              is_smith;
	logic [FSUM_W-1:0] factor_digit_sum;
	logic [NSUM_W-1:0] number_digit_sum;

	logic [NUM_W-1:0] pending_words[$];
	smith_res_t       expected_res[$];
	bit               prime_tbl[0:SIEVE_LIMIT-1];
	int               gap_pct;
	bit               hold_off;
	bit               stim_done;
	int               mismatches;
	int               idle_cycles;

	smith_number_checker dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .number(number),
		.done(done), .is_smith(is_smith), .factor_digit_sum(factor_digit_sum),
		.number_digit_sum(number_digit_sum)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int dsum(int v);
		int s;
		s = 0;
		while (v > 0) begin
			s += v % 10;
			v /= 10;
		end
		return s;
	endfunction

	function automatic smith_res_t predict_smith(logic [NUM_W-1:0] n);
		smith_res_t r;
		int rem, fs, nv;
		nv = n;
		rem = nv;
		fs = 0;
		r.nsum = NSUM_W'(dsum(nv));
		if (nv == 0) begin
			r.smith = 1'b0;
			r.fsum = '0;
			return r;
		end
		if (rem / 2 >= 2) begin
			while (rem % 2 == 0) begin
				rem /= 2;
				fs += 2;
			end
			for (int p = 3; p <= SIEVE_LIMIT; p += 2) begin
				if (p > rem / 2)
					break;
				if (prime_tbl[p])
					while (rem % p == 0) begin
						rem /= p;
						fs += dsum(p);
					end
			end
		end
		if (rem != 1 && rem != nv)
			fs += dsum(rem);
		r.smith = (fs == dsum(nv));
		r.fsum = FSUM_W'(fs);
		return r;
	endfunction

	function automatic void queue_word(logic [NUM_W-1:0] w);
		pending_words.insert(pending_words.size(), w);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			number <= '0;
		end else begin
			if (start && !busy)
				expected_res.insert(expected_res.size(), predict_smith(number));
			if (start && busy) begin
				// word still pending
			end else if (pending_words.size() > 0 && !hold_off &&
					$urandom_range(99) >= gap_pct) begin
				start <= 1'b1;
				number <= pending_words.pop_front();
			end else begin
				start <= 1'b0;
				number <= NUM_W'($urandom);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_res.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word smith=%0d fsum=%0d nsum=%0d",
							is_smith, factor_digit_sum, number_digit_sum);
				end else begin
					smith_res_t e;
					e = expected_res.pop_front();
					if (e.smith !== is_smith || e.fsum !== factor_digit_sum ||
							e.nsum !== number_digit_sum) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
								e.smith, e.fsum, e.nsum, is_smith,
								factor_digit_sum, number_digit_sum);
					end
				end
			end
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_words.size() > 0 || start || expected_res.size() > 0)
			@(posedge clk);
	endtask

	task automatic add_random(int cnt);
		for (int i = 0; i < cnt; i++) begin
			// mostly small values keep the trial division short
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: queue_word(NUM_W'($urandom_range(1, 999)));
				6, 7: queue_word(NUM_W'($urandom_range(1000, 4095)));
				default: queue_word(NUM_W'($urandom_range(1, SIEVE_LIMIT - 1)));
			endcase
		end
	endtask

	initial begin
		int known[$];
		known = '{1, 2, 3, 4, 22, 27, 58, 85, 666, 4937775 % 16384, 9999, 10000,
			8191, 8192, 16381, 16383, 16382, 12287, 3125, 49, 121, 4096, 9973,
			10001};
		for (int i = 0; i < SIEVE_LIMIT; i++)
			prime_tbl[i] = (i >= 2);
		for (int i = 2; i * i < SIEVE_LIMIT; i++)
			if (prime_tbl[i])
				for (int j = i * i; j < SIEVE_LIMIT; j += i)
					prime_tbl[j] = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		hold_off = 1'b0;
		stim_done = 1'b0;
		gap_pct = 12;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		foreach (known[i])
			queue_word(NUM_W'(known[i]));
		queue_word(NUM_W'(14'h2AAA));
		queue_word(NUM_W'(14'h1555));
		add_random(80);
		wait_drained();
		// once all results are in, the sender is held off, then resumes
		hold_off = 1'b1;
		repeat (50) @(posedge clk);
		hold_off = 1'b0;
		gap_pct = 68;
		add_random(90);
		wait_drained();
		gap_pct = 0;
		add_random(95);
		wait_drained();
		repeat (5000) @(posedge clk);
		if (mismatches == 0 && expected_res.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
